/* design/wetach_pkg.sv */
// ----------------------------------------------------------------------------
// wetach_pkg: shared types and constants of the wheel encoder tachometer
// Wheel count, divider sizes, direction codes, register indexes and the
// snapshot that carries one queried wheel from the wheel state to the divider.
// ----------------------------------------------------------------------------
package wetach_pkg;

    localparam int WHEELS     = 4;
    localparam int TICKS_BITS = 12;
    localparam int TIME_W     = 32;

    // 60e6 * 256, the rpm numerator in q8
    localparam int NUM_BITS = 34;
    localparam logic [NUM_BITS-1:0] RPM_NUM = 34'd15360000000;
    localparam int DEN_BITS = TIME_W + TICKS_BITS;
    localparam int CNT_BITS = $clog2(NUM_BITS);

    localparam logic [TICKS_BITS-1:0] TICKS_RESET = 12'd20;
    localparam logic [TIME_W-1:0]     STALE_RESET = 32'd200000;

    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PULSES_PER_TURN = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_STALE_LIMIT     = 1'b1;

    localparam logic [1:0] DIR_ZERO = 2'b00;
    localparam logic [1:0] DIR_POS  = 2'b01;
    localparam logic [1:0] DIR_NEG  = 2'b11;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_SETUP,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    typedef struct packed {
        logic [31:0]       count;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] edge_time;
        logic [TIME_W-1:0] now;
        logic [1:0]        dir;
        logic              ref_valid;
    } wetach_snap_t;

    // pattern 10 counts as reverse
    function automatic logic [1:0] dir_decode(input logic [1:0] code);
        logic [1:0] d;
        case (code)
            DIR_ZERO: d = DIR_ZERO;
            DIR_POS:  d = DIR_POS;
            default:  d = DIR_NEG;
        endcase
        return d;
    endfunction

endpackage

/* design/wetach_wheel_state.sv */
// ----------------------------------------------------------------------------
// wetach_wheel_state: per-wheel edge timing and pulse counting
// Applies clear, direction changes and rising edges for every wheel on an
// accepted sample and captures the queried wheel's updated state.
// ----------------------------------------------------------------------------
module wetach_wheel_state
    import wetach_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [WHEELS-1:0]          pin_levels,
    input  logic [TIME_W-1:0]          now_us,
    input  logic [WHEELS-1:0][1:0]     dir_set,
    input  logic [1:0]                 query_wheel,
    input  logic                       clear_all,
    output wetach_snap_t               snap
);

    logic                primed_reg;
    logic [WHEELS-1:0]   prev_levels_reg;
    logic [TIME_W-1:0]   edge_time_reg   [WHEELS];
    logic [TIME_W-1:0]   edge_time_next  [WHEELS];
    logic [TIME_W-1:0]   period_reg      [WHEELS];
    logic [TIME_W-1:0]   period_next     [WHEELS];
    logic [31:0]         count_reg       [WHEELS];
    logic [31:0]         count_next      [WHEELS];
    logic [1:0]          dir_reg         [WHEELS];
    logic [1:0]          dir_next        [WHEELS];
    logic [WHEELS-1:0]   ref_reg;
    logic [WHEELS-1:0]   ref_next;
    logic [WHEELS-1:0]   rising;
    wetach_snap_t        snap_reg;
    wetach_snap_t        snap_next;

    assign rising = pin_levels & ~prev_levels_reg;

    always_comb
    begin
        logic [TIME_W-1:0] t_c;
        logic [TIME_W-1:0] per_c;
        logic [31:0]       cnt_c;
        logic [1:0]        dir_c;
        logic [1:0]        d;
        logic              ref_c;
        for (int w = 0; w < WHEELS; w++)
        begin
            t_c   = clear_all ? '0 : edge_time_reg[w];
            per_c = clear_all ? '0 : period_reg[w];
            cnt_c = clear_all ? '0 : count_reg[w];
            dir_c = clear_all ? DIR_ZERO : dir_reg[w];
            ref_c = clear_all ? 1'b0 : ref_reg[w];
            d     = dir_decode(dir_set[w]);
            // direction change drops the timing reference
            if (d != dir_c)
            begin
                dir_c = d;
                ref_c = 1'b0;
                t_c   = '0;
                per_c = '0;
            end
            if (primed_reg && rising[w])
            begin
                if (ref_c)
                begin
                    per_c = now_us - t_c;
                    cnt_c = cnt_c + {{30{dir_c[1]}}, dir_c};
                end
                t_c   = now_us;
                ref_c = 1'b1;
            end
            edge_time_next[w] = t_c;
            period_next[w]    = per_c;
            count_next[w]     = cnt_c;
            dir_next[w]       = dir_c;
            ref_next[w]       = ref_c;
        end
    end

    always_comb
    begin
        snap_next.count     = count_next[query_wheel];
        snap_next.period    = period_next[query_wheel];
        snap_next.edge_time = edge_time_next[query_wheel];
        snap_next.now       = now_us;
        snap_next.dir       = dir_next[query_wheel];
        snap_next.ref_valid = ref_next[query_wheel];
        // a query past the last wheel reports zero count and zero rpm
        if ({1'b0, query_wheel} >= 3'(WHEELS))
        begin
            snap_next.count     = '0;
            snap_next.ref_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg      <= 1'b0;
            prev_levels_reg <= '0;
            ref_reg         <= '0;
            snap_reg        <= '0;
            for (int w = 0; w < WHEELS; w++)
            begin
                edge_time_reg[w] <= '0;
                period_reg[w]    <= '0;
                count_reg[w]     <= '0;
                dir_reg[w]       <= DIR_ZERO;
            end
        end
        else if (accept)
        begin
            primed_reg      <= 1'b1;
            prev_levels_reg <= pin_levels;
            ref_reg         <= ref_next;
            snap_reg        <= snap_next;
            for (int w = 0; w < WHEELS; w++)
            begin
                edge_time_reg[w] <= edge_time_next[w];
                period_reg[w]    <= period_next[w];
                count_reg[w]     <= count_next[w];
                dir_reg[w]       <= dir_next[w];
            end
        end
    end

    assign snap = snap_reg;

endmodule

/* design/wetach_rpm_div.sv */
// ----------------------------------------------------------------------------
// wetach_rpm_div: bit-serial rpm divider
// Forms period * ticks, then shifts out one quotient bit per cycle of
// 60e6*256 / den by restoring division, and signs and saturates the result.
// ----------------------------------------------------------------------------
module wetach_rpm_div
    import wetach_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  take,
    input  logic [TICKS_BITS-1:0] ticks,
    input  logic [TIME_W-1:0]     stale_limit,
    input  wetach_snap_t          snap,
    output logic                  busy,
    output logic                  done,
    output logic [31:0]           rpm
);

    div_state_t            state_reg, state_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [DEN_BITS-1:0]   den_reg, den_next;
    logic [DEN_BITS-1:0]   rem_reg, rem_next;
    logic [NUM_BITS-1:0]   num_reg, num_next;
    logic [NUM_BITS-1:0]   quo_reg, quo_next;
    logic                  zero_reg, zero_next;
    logic                  neg_reg, neg_next;
    logic [DEN_BITS-1:0]   rem_sh;
    logic [DEN_BITS-1:0]   product;
    logic [TIME_W-1:0]     age;
    logic                  fits;
    logic                  over;

    // remainder never exceeds the numerator prefix, so the top bit is free
    assign rem_sh  = {rem_reg[DEN_BITS-2:0], num_reg[NUM_BITS-1]};
    assign fits    = (rem_sh >= den_reg);
    assign product = snap.period * ticks;
    assign age     = snap.now - snap.edge_time;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        num_next   = num_reg;
        quo_next   = quo_reg;
        zero_next  = zero_reg;
        neg_next   = neg_reg;
        case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                    state_next = DIV_SETUP;
            end
            DIV_SETUP:
            begin
                den_next  = product;
                zero_next = !snap.ref_valid || (snap.period == '0) ||
                            (snap.dir == DIR_ZERO) || (age > stale_limit) ||
                            (ticks == '0);
                neg_next  = snap.dir[1];
                rem_next  = '0;
                num_next  = RPM_NUM;
                quo_next  = '0;
                cnt_next  = CNT_BITS'(NUM_BITS - 1);
                state_next = DIV_RUN;
            end
            DIV_RUN:
            begin
                num_next = {num_reg[NUM_BITS-2:0], 1'b0};
                quo_next = {quo_reg[NUM_BITS-2:0], fits};
                rem_next = fits ? (rem_sh - den_reg) : rem_sh;
                if (cnt_reg == '0)
                    state_next = DIV_DONE;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            DIV_DONE:
            begin
                if (take)
                    state_next = DIV_IDLE;
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            cnt_reg   <= '0;
            zero_reg  <= 1'b1;
            neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            zero_reg  <= zero_next;
            neg_reg   <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= den_next;
        rem_reg <= rem_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
    end

    assign over = |quo_reg[NUM_BITS-1:31];

    always_comb
    begin
        if (zero_reg)
            rpm = '0;
        else if (neg_reg)
            rpm = over ? 32'h8000_0000 : (32'd0 - quo_reg[31:0]);
        else
            rpm = over ? 32'h7fff_ffff : quo_reg[31:0];
    end

    assign busy = (state_reg != DIV_IDLE);
    assign done = (state_reg == DIV_DONE);

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == DIV_RUN && !zero_reg |-> rem_reg < den_reg)
        else $error("divider remainder not below denominator");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        done && zero_reg |-> rpm == '0)
        else $error("suppressed rpm is not zero");

    a_forward_sign: assert property (@(posedge clk) disable iff (!rst_n)
        done && !neg_reg |-> !rpm[31])
        else $error("forward rpm came out negative");

endmodule

/* design/wheel_encoder_tachometer_core.sv */
// ----------------------------------------------------------------------------
// wheel_encoder_tachometer_core: four-wheel single-channel encoder tachometer
// Tracks edge periods and pulse counts per wheel and reports one wheel's
// count and signed q8 rpm for every input sample.
//
// Usage:
//   Input beat: line levels, timestamp, four wheel directions, clear flag and
//   query wheel; taken when in_valid is high and in_stall low. The wheel
//   state updates at that edge; the first beat after reset counts no edge,
//   it records the line levels and applies the directions and clear flag.
//   Output beat: pulse_total and rpm_q8 of the queried wheel, held in an
//   output register until taken with out_valid high and out_stall low.
//   Path to out_valid: a setup state forms period * ticks, the bit-serial
//   rpm divider runs, then the finished quotient loads the output register.
//   in_stall stays high while the divider holds a beat, so the divider sets
//   the rate; a new beat is taken only once the last result has left it.
//   A stalled receiver holds the result; the next input beat is taken while
//   it waits, and its result waits in the divider until the output frees.
//   Config: cfg_we writes pulses per revolution (index 0) or stale_limit_us
//   (1); write only while idle. Reset clears all wheel state and loads 20 and
//   200000 into the registers.
// ----------------------------------------------------------------------------
module wheel_encoder_tachometer_core
    import wetach_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [3:0]              pin_levels,
    input  logic [31:0]             now_us,
    input  logic signed [1:0]       dir_front_left,
    input  logic signed [1:0]       dir_front_right,
    input  logic signed [1:0]       dir_rear_left,
    input  logic signed [1:0]       dir_rear_right,
    input  logic [1:0]              query_wheel,
    input  logic                    clear_all,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [31:0]      pulse_total,
    output logic signed [31:0]      rpm_q8,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [31:0]             cfg_data
);

    logic [TICKS_BITS-1:0]  ticks_reg;
    logic [TIME_W-1:0]      stale_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [31:0]            pulse_total_reg;
    logic [31:0]            rpm_q8_reg;
    logic                   in_accept;
    logic                   div_busy;
    logic                   div_done;
    logic                   load;
    logic [31:0]            div_rpm;
    logic [WHEELS-1:0][1:0] dir_set;
    wetach_snap_t           snap;

    assign in_stall  = div_busy;
    assign in_accept = in_valid && !in_stall;
    assign load      = div_done && (!out_valid_reg || !out_stall);

    assign dir_set = {dir_rear_right, dir_rear_left, dir_front_right, dir_front_left};

    wetach_wheel_state u_wheels (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .pin_levels  (pin_levels),
        .now_us      (now_us),
        .dir_set     (dir_set),
        .query_wheel (query_wheel),
        .clear_all   (clear_all),
        .snap        (snap)
    );

    wetach_rpm_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (in_accept),
        .take        (load),
        .ticks       (ticks_reg),
        .stale_limit (stale_reg),
        .snap        (snap),
        .busy        (div_busy),
        .done        (div_done),
        .rpm         (div_rpm)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= TICKS_RESET;
            stale_reg <= STALE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PULSES_PER_TURN: ticks_reg <= cfg_data[TICKS_BITS-1:0];
                REG_STALE_LIMIT:     stale_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pulse_total_reg <= snap.count;
            rpm_q8_reg      <= div_rpm;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pulse_total = pulse_total_reg;
    assign rpm_q8      = rpm_q8_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again before the divider started");

    a_load_from_divider: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(div_done))
        else $error("output beat without a finished division");

    a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !div_done |=> !out_valid)
        else $error("output beat repeated after it was taken");

endmodule

/* tb/sv/tb_wheel_encoder_tachometer_core.sv */
// ----------------------------------------------------------------------------
// tb_wheel_encoder_tachometer_core: self-checking bench for the tachometer core
// Drives encoder samples through the valid/stall input channel. A scoreboard
// keeps its own copy of the wheel state and predicts each beat's pulse count
// and q8 rpm. Results are checked in order; outside the calm run both sides idle at random.
// ----------------------------------------------------------------------------
module tb_wheel_encoder_tachometer_core;
    import wetach_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int TIMEOUT_TICKS = 600000 * 2 * CLK_HALF;
    localparam int SETTLE_CYCLES = 40;

    localparam logic [1:0] DIR_ALT_NEG = 2'b10;
    localparam logic [63:0] RPM_Q8_NUMERATOR = 64'd15360000000;

    typedef struct packed {
        logic [3:0]      levels;
        logic [31:0]     now;
        logic [3:0][1:0] dir;
        logic [1:0]      query;
        logic            clear;
    } tach_sample_t;

    class tach_scoreboard;
        logic [11:0] ticks;
        logic [31:0] stale;
        bit          primed;
        logic [3:0]  last_levels;
        logic [31:0] edge_t[4];
        bit          ref_ok[4];
        logic [31:0] period[4];
        logic [31:0] count[4];
        logic [1:0]  dir[4];
        logic [31:0] want_total[$];
        logic [31:0] want_rpm[$];
        int          errors;
        int          checked;

        function new();
            ticks = TICKS_RESET;
            stale = STALE_RESET;
            primed = 0;
            last_levels = '0;
            errors = 0;
            checked = 0;
            clear_wheels();
        endfunction

        function void clear_wheels();
            for (int w = 0; w < 4; w++)
            begin
                edge_t[w] = '0;
                ref_ok[w] = 0;
                period[w] = '0;
                count[w]  = '0;
                dir[w]    = DIR_ZERO;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] data);
            if (idx == REG_PULSES_PER_TURN)
                ticks = data[11:0];
            else if (idx == REG_STALE_LIMIT)
                stale = data;
        endfunction

        function logic [31:0] rpm_for(int w, logic [31:0] now);
            logic [31:0] age;
            logic [43:0] den;
            logic [63:0] mag;
            age = now - edge_t[w];
            if (!ref_ok[w] || period[w] == 0 || dir[w] == DIR_ZERO)
                return '0;
            if (age > stale || ticks == 0)
                return '0;
            den = 44'(period[w]) * 44'(ticks);
            mag = RPM_Q8_NUMERATOR / 64'(den);
            if (dir[w] == DIR_POS)
                return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
            return (mag > 64'h8000_0000) ? 32'h8000_0000 : -mag[31:0];
        endfunction

        function void note_sample(tach_sample_t s);
            logic [3:0] rising;
            logic [1:0] code;
            if (s.clear)
                clear_wheels();
            for (int w = 0; w < 4; w++)
            begin
                // any nonzero code other than forward means reverse
                if (s.dir[w] == DIR_ZERO)
                    code = DIR_ZERO;
                else if (s.dir[w] == DIR_POS)
                    code = DIR_POS;
                else
                    code = DIR_NEG;
                if (code != dir[w])
                begin
                    dir[w]    = code;
                    ref_ok[w] = 0;
                    edge_t[w] = '0;
                    period[w] = '0;
                end
            end
            if (!primed)
                primed = 1;
            else
            begin
                rising = s.levels & ~last_levels;
                for (int w = 0; w < 4; w++)
                begin
                    if (rising[w])
                    begin
                        // first edge after a lost reference only re-arms timing
                        if (ref_ok[w])
                        begin
                            period[w] = s.now - edge_t[w];
                            if (dir[w] == DIR_POS)
                                count[w] = count[w] + 32'd1;
                            else if (dir[w] == DIR_NEG)
                                count[w] = count[w] - 32'd1;
                        end
                        edge_t[w] = s.now;
                        ref_ok[w] = 1;
                    end
                end
            end
            last_levels = s.levels;
            want_total.push_back(count[s.query]);
            want_rpm.push_back(rpm_for(s.query, s.now));
        endfunction

        function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d",
                     $time, field, $signed(exp_v), $signed(act_v));
        endfunction

        function void check_result(logic [31:0] total, logic [31:0] rpm);
            logic [31:0] exp_total;
            logic [31:0] exp_rpm;
            if (want_total.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing pending, pulse_total %0d rpm_q8 %0d",
                         $time, $signed(total), $signed(rpm));
                return;
            end
            exp_total = want_total.pop_front();
            exp_rpm   = want_rpm.pop_front();
            checked++;
            if (total !== exp_total)
                report("pulse_total", exp_total, total);
            if (rpm !== exp_rpm)
                report("rpm_q8", exp_rpm, rpm);
        endfunction

        function int pending();
            return want_total.size();
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [3:0]              pin_levels = '0;
    logic [31:0]             now_us = '0;
    logic signed [1:0]       dir_front_left = '0;
    logic signed [1:0]       dir_front_right = '0;
    logic signed [1:0]       dir_rear_left = '0;
    logic signed [1:0]       dir_rear_right = '0;
    logic [1:0]              query_wheel = '0;
    logic                    clear_all = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [31:0]      pulse_total;
    logic signed [31:0]      rpm_q8;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [31:0]             cfg_data = '0;

    tach_scoreboard  sb;
    bit              calm = 0;
    int              beats_sent = 0;
    int              settings_used = 1;
    logic [31:0]     cur_now = '0;
    logic [3:0]      cur_levels = '0;
    logic [3:0][1:0] cur_dirs = '0;

    wheel_encoder_tachometer_core u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pin_levels      (pin_levels),
        .now_us          (now_us),
        .dir_front_left  (dir_front_left),
        .dir_front_right (dir_front_right),
        .dir_rear_left   (dir_rear_left),
        .dir_rear_right  (dir_rear_right),
        .query_wheel     (query_wheel),
        .clear_all       (clear_all),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .pulse_total     (pulse_total),
        .rpm_q8          (rpm_q8),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // result side: check the accepted beat, then pick next cycle's stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(pulse_total, rpm_q8);
            out_stall <= !calm && ($urandom_range(99) < 29);
        end
    end

    function automatic tach_sample_t mk(logic [3:0] levels, logic [31:0] now,
                                        logic [3:0][1:0] dirs, logic [1:0] q,
                                        logic clr);
        tach_sample_t s;
        s.levels = levels;
        s.now    = now;
        s.dir    = dirs;
        s.query  = q;
        s.clear  = clr;
        return s;
    endfunction

    task automatic send_sample(input tach_sample_t s);
        int gap;
        in_valid        <= 1'b1;
        pin_levels      <= s.levels;
        now_us          <= s.now;
        dir_front_left  <= s.dir[0];
        dir_front_right <= s.dir[1];
        dir_rear_left   <= s.dir[2];
        dir_rear_right  <= s.dir[3];
        query_wheel     <= s.query;
        clear_all       <= s.clear;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_sample(s);
        beats_sent++;
        if (!calm && $urandom_range(99) < 29)
        begin
            gap = $urandom_range(1, 45);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off the sender until every pending result has been taken
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_registers(input logic [31:0] ticks, input logic [31:0] stale);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_PULSES_PER_TURN;
        cfg_data  <= ticks;
        @(posedge clk);
        sb.write_reg(REG_PULSES_PER_TURN, ticks);
        cfg_index <= REG_STALE_LIMIT;
        cfg_data  <= stale;
        @(posedge clk);
        sb.write_reg(REG_STALE_LIMIT, stale);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_random(input int items, input int max_step, input bit mid_drain);
        tach_sample_t s;
        int k;
        int step;
        for (int i = 0; i < items; i++)
        begin
            if (mid_drain && i == items / 2)
                drain();
            if ($urandom_range(99) < 85)
            begin
                // plausible wheel motion: time moves on, lines toggle
                k = $urandom_range(99);
                if (k < 10)
                    step = $urandom_range(0, 3);
                else if (k < 95)
                    step = $urandom_range(1, max_step);
                else
                    step = $urandom_range(100000, 400000);
                cur_now = cur_now + step;
                cur_levels = cur_levels ^ 4'($urandom_range(15));
                for (int w = 0; w < 4; w++)
                    if ($urandom_range(99) < 3)
                        cur_dirs[w] = 2'($urandom_range(3));
                s = mk(cur_levels, cur_now, cur_dirs, 2'($urandom_range(3)),
                       $urandom_range(99) < 2);
            end
            else
            begin
                cur_now    = $urandom;
                cur_levels = 4'($urandom_range(15));
                cur_dirs   = 8'($urandom_range(255));
                s = mk(cur_levels, cur_now, cur_dirs, 2'($urandom_range(3)),
                       $urandom_range(99) < 10);
            end
            send_sample(s);
        end
    endtask

    initial
    begin
        #TIMEOUT_TICKS;
        $display("timeout with %0d results still pending", sb.pending());
        $display("FAIL wheel_encoder_tachometer_core");
        $finish;
    end

    initial
    begin
        logic [3:0][1:0] mix;
        logic [3:0][1:0] flip;
        sb = new();
        mix  = {DIR_ALT_NEG, DIR_ZERO, DIR_NEG, DIR_POS};
        flip = {DIR_ALT_NEG, DIR_ZERO, DIR_NEG, DIR_NEG};
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first beat primes the line levels and sets the directions; it counts no edge
        send_sample(mk(4'hF, 32'd0, mix, 2'd0, 1'b0));
        send_sample(mk(4'h0, 32'd100, mix, 2'd0, 1'b0));
        send_sample(mk(4'hF, 32'd1000, mix, 2'd1, 1'b0));
        send_sample(mk(4'h0, 32'd1500, mix, 2'd2, 1'b0));
        send_sample(mk(4'hF, 32'd2000, mix, 2'd0, 1'b0));
        send_sample(mk(4'hF, 32'd2100, mix, 2'd1, 1'b0));
        send_sample(mk(4'hF, 32'd2200, mix, 2'd2, 1'b0));
        send_sample(mk(4'hF, 32'd2300, mix, 2'd3, 1'b0));
        // age right at the stale limit, then one past it
        send_sample(mk(4'hF, 32'd202000, mix, 2'd0, 1'b0));
        send_sample(mk(4'hF, 32'd202001, mix, 2'd0, 1'b0));
        // period measured across the timestamp wrap
        send_sample(mk(4'h0, 32'hFFFF_FF00, mix, 2'd0, 1'b0));
        send_sample(mk(4'hF, 32'hFFFF_FF80, mix, 2'd0, 1'b0));
        send_sample(mk(4'h0, 32'hFFFF_FFC0, mix, 2'd1, 1'b0));
        send_sample(mk(4'hF, 32'h0000_0070, mix, 2'd0, 1'b0));
        send_sample(mk(4'hF, 32'h0000_0080, mix, 2'd3, 1'b1));
        send_sample(mk(4'h0, 32'h0000_0090, mix, 2'd0, 1'b0));
        send_sample(mk(4'hF, 32'h0000_0100, mix, 2'd0, 1'b0));
        send_sample(mk(4'h0, 32'h0000_0101, mix, 2'd1, 1'b0));
        send_sample(mk(4'hF, 32'h0000_0103, mix, 2'd0, 1'b0));

        // zero ticks per revolution reads as no rpm
        set_registers(32'd0, STALE_RESET);
        send_sample(mk(4'h0, 32'h0000_0104, mix, 2'd0, 1'b0));
        send_sample(mk(4'hF, 32'h0000_0105, mix, 2'd0, 1'b0));

        // one tick per revolution and a short period saturate both signs
        set_registers(32'd1, STALE_RESET);
        send_sample(mk(4'hF, 32'h0000_0106, mix, 2'd0, 1'b0));
        send_sample(mk(4'hF, 32'h0000_0106, mix, 2'd1, 1'b0));
        send_sample(mk(4'hF, 32'h0000_0107, mix, 2'd3, 1'b0));
        // a direction change drops the front left reference
        send_sample(mk(4'hF, 32'h0000_0108, flip, 2'd0, 1'b0));

        cur_now    = 32'h0000_0108;
        cur_levels = 4'hF;
        cur_dirs   = flip;

        set_registers(32'd20, STALE_RESET);
        run_random(220, 3000, 1'b0);

        set_registers(32'd1, 32'hFFFF_FFFF);
        run_random(200, 50, 1'b0);

        set_registers(32'd4095, 32'd1);
        calm = 1;
        run_random(200, 2000, 1'b0);
        calm = 0;

        set_registers(32'($urandom_range(1, 4095)), $urandom);
        run_random(230, 3000, 1'b0);

        set_registers(32'd20, STALE_RESET);
        run_random(200, 3000, 1'b1);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d sample beats, %0d results checked, %0d register settings",
                 beats_sent, sb.checked, settings_used);
        $display("%0d mismatches seen", sb.errors);
        if (sb.errors == 0)
            $display("PASS wheel_encoder_tachometer_core");
        else
            $display("FAIL wheel_encoder_tachometer_core");
        $finish;
    end

endmodule
